// ----- design/assert_macros.svh -----
// Assertion helpers for the RTL files of this project; only the receiver core includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on a given clock, switched off while the given reset is high.
`define DFR_ASSERT_CLKRST(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);
// Same, on the usual clk and rst of the module.
`define DFR_ASSERT(label, prop, msg) \
  `DFR_ASSERT_CLKRST(label, clk, rst, prop, msg)
`else
`define DFR_ASSERT_CLKRST(label, clk_s, rst_s, prop, msg)
`define DFR_ASSERT(label, prop, msg)
`endif

`endif

// ----- design/dfr_pkg.sv -----
`default_nettype none

package dfr_pkg;

  // Line control bytes.
  localparam logic [7:0] DLE      = 8'h10;
  localparam logic [7:0] STX      = 8'h00;
  localparam logic [7:0] ETX      = 8'hFF;
  localparam logic [7:0] ACK      = 8'h11;
  localparam logic [7:0] NAK      = 8'h12;
  localparam logic [7:0] TYPE_RST = 8'h91;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_IDLE_ESC = 3'd1,
    PH_SEQ      = 3'd2,
    PH_SEQ_ESC  = 3'd3,
    PH_TYPE     = 3'd4,
    PH_BODY     = 3'd5,
    PH_BODY_ESC = 3'd6
  } phase_t;

  typedef enum logic [3:0] {
    EV_PAYLOAD  = 4'd0,
    EV_ACCEPT   = 4'd1,
    EV_REPEAT   = 4'd2,
    EV_CRC_NAK  = 4'd3,
    EV_SEQ_NAK  = 4'd4,
    EV_TYPE_NAK = 4'd5,
    EV_PEER_ACK = 4'd6,
    EV_PEER_NAK = 4'd7,
    EV_ABORT    = 4'd8,
    EV_TOO_LONG = 4'd9
  } event_kind_t;

  typedef struct packed {
    logic [3:0]  event_kind;
    logic [7:0]  payload_byte;
    logic [11:0] payload_length;
  } dfr_evt_t;

  // One byte of CRC-16/XMODEM (poly 0x1021, MSB first), table-free form.
  function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = {c[7:0], c[15:8]} ^ {8'h00, b};
    x = x ^ {12'h000, x[7:4]};
    x = x ^ {x[3:0], 12'h000};
    x = x ^ {3'b000, x[7:0], 5'b00000};
    return x;
  endfunction

endpackage

`default_nettype wire

// ----- design/dfr_if.sv -----
`default_nettype none

// Raw line bytes.
interface dfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Receiver events.
interface dfr_evt_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_kind;
  logic [7:0]  payload_byte;
  logic [11:0] payload_length;
  modport source (output valid, output event_kind, output payload_byte,
                  output payload_length, input ready);
  modport sink (input valid, input event_kind, input payload_byte,
                input payload_length, output ready);
endinterface

// Write channel of the expected frame type register.
interface dfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] expected_frame_type;
  modport source (output valid, output expected_frame_type, input ready);
  modport sink (input valid, input expected_frame_type, output ready);
endinterface

`default_nettype wire

// ----- design/dfr_ram.sv -----
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module dfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/dle_frame_receiver_crc_dedup_core.sv -----
`default_nettype none
`include "assert_macros.svh"

// Receiver for DLE-stuffed frames (0x10 0x00 opens, 0x10 0xFF closes, a data
// 0x10 is doubled) with a CRC-16/XMODEM check over seq, type and payload and
// duplicate detection against the last accepted frame. One raw line byte is
// taken per request on rx, every clock cycle if offered: the CRC update, the
// bank write and the read for the byte-by-byte duplicate compare all happen
// in the same cycle, and the compare against the read data closes in the next.
// Payload bytes come out on result tentatively, two body bytes late, and a
// verdict event (accept, repeat, bad CRC, reused seq, bad type, aborted, too
// long) follows each frame end; peer ACK and NAK are reported as they arrive,
// NAK only between frames. Events pass through an output register and a skid
// register, so rx stalls only when both hold events that result has not taken.
// Frame bytes live in one RAM of 2 ** ($clog2(FRAME_BYTES) + 1) entries in two
// banks that swap roles on every accepted frame; it has no clearing pass and is
// ready at once after reset. The user writes the expected type register through
// cfg only while idle, which the block does not enforce; the register resets to 0x91.
module dle_frame_receiver_crc_dedup_core #(
  parameter int FRAME_BYTES = 4096
) (
  input wire logic clk,
  input wire logic rst,
  dfr_rx_if.sink   rx,
  dfr_cfg_if.sink  cfg,
  dfr_evt_if.source result
);

  localparam int CW = $clog2(FRAME_BYTES + 2);
  localparam int IW = $clog2(FRAME_BYTES);
  localparam int AW = IW + 1;
  localparam int LW = (CW > 12) ? CW : 12;
  localparam logic [CW-1:0] FULL = CW'(FRAME_BYTES);
  localparam logic [CW-1:0] OVER = CW'(FRAME_BYTES + 1);
  localparam logic [CW-1:0] HDR  = CW'(4);

  // Receive state.
  dfr_pkg::phase_t phase, phase_next;
  logic [CW-1:0]   count, count_next;
  logic [15:0]     crc, crc_next;
  logic            same_last, same_last_next;
  logic [7:0]      held0, held0_next, held1, held1_next;
  logic [7:0]      cur_seq, cur_seq_next;

  // Last accepted frame.
  logic            last_sel, last_sel_next;
  logic            last_valid, last_valid_next;
  logic [CW-1:0]   last_len, last_len_next;
  logic [7:0]      last_seq, last_seq_next;

  logic [7:0]      exp_type;

  // Duplicate compare in flight: the byte waits for the last bank's read data.
  logic            cmp_pending;
  logic [7:0]      cmp_byte;
  logic            cmp_issue;

  // Output register and skid register.
  logic            out_valid, sk_valid;
  dfr_pkg::dfr_evt_t out_evt, sk_evt, res_evt;

  logic            in_acc, res_valid, push, pop;
  logic [7:0]      b;
  logic            store_en, crc_en, do_begin;
  logic [7:0]      crc_in;
  logic [LW-1:0]   len_w;
  logic [11:0]     rep_len;
  dfr_pkg::event_kind_t res_kind;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [7:0]      ram_rdata;

  assign b      = rx.rx_byte;
  assign in_acc = rx.valid && rx.ready;
  assign rx.ready = !sk_valid;
  assign cfg.ready = 1'b1;

  // Payload count the verdict events report.
  always_comb begin
    if (count > FULL) begin
      len_w = LW'(FRAME_BYTES - 4);
    end else if (count >= HDR) begin
      len_w = LW'(count) - LW'(4);
    end else begin
      len_w = '0;
    end
  end
  assign rep_len = len_w[11:0];

  always_comb begin
    phase_next      = phase;
    count_next      = count;
    crc_next        = crc;
    same_last_next  = same_last;
    held0_next      = held0;
    held1_next      = held1;
    cur_seq_next    = cur_seq;
    last_sel_next   = last_sel;
    last_valid_next = last_valid;
    last_len_next   = last_len;
    last_seq_next   = last_seq;
    res_valid       = 1'b0;
    res_kind        = dfr_pkg::EV_PAYLOAD;
    res_evt         = '0;
    store_en        = 1'b0;
    crc_en          = 1'b0;
    crc_in          = b;
    do_begin        = 1'b0;
    cmp_issue       = 1'b0;

    // The compare issued in the previous cycle closes now.
    if (cmp_pending && (ram_rdata != cmp_byte)) begin
      same_last_next = 1'b0;
    end

    if (in_acc) begin
      case (phase)
        dfr_pkg::PH_IDLE_ESC: begin
          phase_next = dfr_pkg::PH_IDLE;
          if (b == dfr_pkg::STX) begin
            do_begin   = 1'b1;
            phase_next = dfr_pkg::PH_SEQ;
          end else if (b == dfr_pkg::ACK) begin
            res_valid = 1'b1;
            res_kind  = dfr_pkg::EV_PEER_ACK;
          end else if (b == dfr_pkg::NAK) begin
            res_valid = 1'b1;
            res_kind  = dfr_pkg::EV_PEER_NAK;
          end
        end
        dfr_pkg::PH_SEQ: begin
          if (b == dfr_pkg::DLE) begin
            phase_next = dfr_pkg::PH_SEQ_ESC;
          end else begin
            store_en   = 1'b1;
            crc_en     = 1'b1;
            phase_next = dfr_pkg::PH_TYPE;
          end
        end
        dfr_pkg::PH_SEQ_ESC: begin
          if (b == dfr_pkg::DLE) begin
            store_en   = 1'b1;
            crc_en     = 1'b1;
            phase_next = dfr_pkg::PH_TYPE;
          end else begin
            phase_next = dfr_pkg::PH_SEQ;
          end
        end
        dfr_pkg::PH_TYPE: begin
          // The type byte is taken raw, without unstuffing.
          if (b != exp_type) begin
            phase_next = dfr_pkg::PH_IDLE;
            res_valid  = 1'b1;
            res_kind   = dfr_pkg::EV_TYPE_NAK;
          end else begin
            store_en   = 1'b1;
            crc_en     = 1'b1;
            phase_next = dfr_pkg::PH_BODY;
          end
        end
        dfr_pkg::PH_BODY, dfr_pkg::PH_BODY_ESC: begin
          phase_next = dfr_pkg::PH_BODY;
          if (phase == dfr_pkg::PH_BODY && b == dfr_pkg::DLE) begin
            phase_next = dfr_pkg::PH_BODY_ESC;
          end else if (phase == dfr_pkg::PH_BODY || b == dfr_pkg::DLE) begin
            // One body byte. Past the bank size the frame is marked too long.
            if (count >= FULL) begin
              count_next = OVER;
            end else begin
              store_en = 1'b1;
              if (count < HDR) begin
                if (count[0]) begin
                  held1_next = b;
                end else begin
                  held0_next = b;
                end
              end else begin
                crc_en     = 1'b1;
                crc_in     = held0;
                held0_next = held1;
                held1_next = b;
                res_valid  = 1'b1;
                res_kind   = dfr_pkg::EV_PAYLOAD;
              end
            end
          end else if (b == dfr_pkg::ETX) begin
            phase_next = dfr_pkg::PH_IDLE;
            res_valid  = 1'b1;
            if (count > FULL) begin
              res_kind = dfr_pkg::EV_TOO_LONG;
            end else if (count < HDR || held0 != crc[15:8] || held1 != crc[7:0]) begin
              res_kind = dfr_pkg::EV_CRC_NAK;
            end else if (!last_valid || cur_seq != last_seq) begin
              res_kind        = dfr_pkg::EV_ACCEPT;
              last_sel_next   = !last_sel;
              last_valid_next = 1'b1;
              last_len_next   = count;
              last_seq_next   = cur_seq;
            end else if (same_last && count == last_len) begin
              res_kind = dfr_pkg::EV_REPEAT;
            end else begin
              res_kind = dfr_pkg::EV_SEQ_NAK;
            end
          end else if (b == dfr_pkg::ACK) begin
            res_valid = 1'b1;
            res_kind  = dfr_pkg::EV_PEER_ACK;
          end else if (b == dfr_pkg::STX) begin
            res_valid  = 1'b1;
            res_kind   = dfr_pkg::EV_ABORT;
            do_begin   = 1'b1;
            phase_next = dfr_pkg::PH_SEQ;
          end
        end
        default: begin
          // Idle, and the unused phase code.
          phase_next = (b == dfr_pkg::DLE) ? dfr_pkg::PH_IDLE_ESC : dfr_pkg::PH_IDLE;
        end
      endcase
    end

    // Store a frame byte into the current bank and, where the last frame has a byte at that place, start its compare.
    if (store_en) begin
      if (!last_valid || count >= last_len) begin
        same_last_next = 1'b0;
      end else begin
        cmp_issue = 1'b1;
      end
      if (count == '0) begin
        cur_seq_next = b;
      end
      count_next = count + CW'(1);
    end

    if (crc_en) begin
      crc_next = dfr_pkg::crc_update(crc, crc_in);
    end

    if (do_begin) begin
      count_next     = '0;
      crc_next       = '0;
      same_last_next = 1'b1;
      held0_next     = '0;
      held1_next     = '0;
    end

    res_evt.event_kind = res_kind;
    if (res_kind == dfr_pkg::EV_PAYLOAD) begin
      res_evt.payload_byte = held0;
    end
    if (!(res_kind inside {dfr_pkg::EV_PAYLOAD, dfr_pkg::EV_TYPE_NAK, dfr_pkg::EV_PEER_ACK,
                           dfr_pkg::EV_PEER_NAK})) begin
      res_evt.payload_length = rep_len;
    end
  end

  // The current bank is the one not holding the last accepted frame.
  assign ram_we    = store_en;
  assign ram_waddr = {!last_sel, count[IW-1:0]};
  assign ram_raddr = {last_sel, count[IW-1:0]};

  dfr_ram #(
    .WIDTH (8),
    .DEPTH (2 ** AW)
  ) u_banks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (b),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= dfr_pkg::PH_IDLE;
      count       <= '0;
      crc         <= '0;
      same_last   <= 1'b1;
      held0       <= '0;
      held1       <= '0;
      last_sel    <= 1'b0;
      last_valid  <= 1'b0;
      last_len    <= '0;
      exp_type    <= dfr_pkg::TYPE_RST;
      cmp_pending <= 1'b0;
    end else begin
      phase       <= phase_next;
      count       <= count_next;
      crc         <= crc_next;
      same_last   <= same_last_next;
      held0       <= held0_next;
      held1       <= held1_next;
      last_sel    <= last_sel_next;
      last_valid  <= last_valid_next;
      last_len    <= last_len_next;
      cmp_pending <= cmp_issue;
      if (cfg.valid) begin
        exp_type <= cfg.expected_frame_type;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_seq  <= cur_seq_next;
    last_seq <= last_seq_next;
    cmp_byte <= b;
  end

  // Output register with a skid register behind it. rx is ready whenever the
  // skid register is empty, so a new event always finds a place.
  assign push = in_acc && res_valid;
  assign pop  = out_valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (sk_valid) begin
      if (pop) begin
        out_valid <= 1'b1;
        sk_valid  <= 1'b0;
      end
    end else if (!out_valid || pop) begin
      out_valid <= push;
    end else if (push) begin
      sk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_valid) begin
      if (pop) begin
        out_evt <= sk_evt;
      end
    end else if (!out_valid || pop) begin
      out_evt <= res_evt;
    end else if (push) begin
      sk_evt <= res_evt;
    end
  end

  assign result.valid          = out_valid;
  assign result.event_kind     = out_evt.event_kind;
  assign result.payload_byte   = out_evt.payload_byte;
  assign result.payload_length = out_evt.payload_length;

  // The skid register fills only behind a held output register.
  `DFR_ASSERT(a_skid_behind_out, sk_valid |-> out_valid, "skid full with output empty")
  // The frame byte count never goes past the too-long mark.
  `DFR_ASSERT(a_count_range, count <= OVER, "frame byte count out of range")
  // A compare closes only in the cycle after its store.
  `DFR_ASSERT(a_cmp_after_store, cmp_pending |-> $past(cmp_issue), "compare without a store")
  // The escape byte stores nothing, so no compare is still open at the byte after it.
  `DFR_ASSERT(a_no_open_cmp_at_esc,
              (in_acc && phase == dfr_pkg::PH_BODY_ESC) |-> !cmp_pending,
              "compare still open at escape")
  // A stored frame becomes valid only through an accept event.
  `DFR_ASSERT(a_valid_by_accept,
              $rose(last_valid) |-> $past(push && res_kind == dfr_pkg::EV_ACCEPT),
              "last frame valid without accept")

endmodule

`default_nettype wire
